// ===== src/stfs_pkg.sv =====
// ----------------------------------------------------------------------------
// stfs_pkg
// shared types and constants for the slot table with first-free allocation
// ----------------------------------------------------------------------------
package stfs_pkg;

    localparam int MODE_W = 3;
    localparam int ID_W   = 16;
    localparam int SLOT_W = 8;
    localparam int CNT_W  = 9;

    typedef enum logic [MODE_W-1:0] {
        MODE_ADD_FIRST = 3'd0,
        MODE_ADD_SLOT  = 3'd1,
        MODE_REM_ID    = 3'd2,
        MODE_REM_SLOT  = 3'd3,
        MODE_SWAP      = 3'd4,
        MODE_READ      = 3'd5,
        MODE_CLEAR     = 3'd6
    } t_mode;

    typedef struct packed {
        logic we;
        logic re;
    } t_ram_cmd;

endpackage

// ===== src/stfs_item_ram.sv =====
// ----------------------------------------------------------------------------
// stfs_item_ram
// single-port id store, one access per cycle, registered read data
// ----------------------------------------------------------------------------
module stfs_item_ram #(
    parameter int SLOTS = 16
) (
    input  logic                                         i_clk,
    input  stfs_pkg::t_ram_cmd                           i_cmd,
    input  logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] i_addr,
    input  logic [stfs_pkg::ID_W-1:0]                    i_wdata,
    output logic [stfs_pkg::ID_W-1:0]                    o_rdata
);
    import stfs_pkg::*;

    logic [ID_W-1:0] r_mem [SLOTS];
    logic [ID_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_cmd.we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_cmd.re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/slot_table_first_free_with_id_search.sv =====
// ----------------------------------------------------------------------------
// slot_table_first_free_with_id_search
// slot table with occupied bits, first-free add, id search and swap
//
//   channel   direction  handshake           payload
//   request   in         i_valid / o_stall   i_mode i_item_id i_slot_a i_slot_b
//   result    out        o_valid / i_stall   o_ok o_slot_out o_item_out
//                                            o_occupied_count o_table_full
//                                            o_table_empty
//
// one request at a time; add first free and remove by id scan the slots, walking
// one slot per cycle through the single port of the id store.
// reset clears the occupied bits and count at once; ids are not reset.
// a new request is taken while a result still waits on i_stall.
// ----------------------------------------------------------------------------
module slot_table_first_free_with_id_search #(
    parameter int SLOTS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [stfs_pkg::MODE_W-1:0]  i_mode,
    input  logic [stfs_pkg::ID_W-1:0]    i_item_id,
    input  logic [stfs_pkg::SLOT_W-1:0]  i_slot_a,
    input  logic [stfs_pkg::SLOT_W-1:0]  i_slot_b,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic                         o_ok,
    output logic [stfs_pkg::SLOT_W-1:0]  o_slot_out,
    output logic [stfs_pkg::ID_W-1:0]    o_item_out,
    output logic [stfs_pkg::CNT_W-1:0]   o_occupied_count,
    output logic                         o_table_full,
    output logic                         o_table_empty
);
    import stfs_pkg::*;

    localparam int               IW       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [IW-1:0]    LAST     = IW'(SLOTS - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(SLOTS);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_FREE_SCAN,
        S_ID_SCAN,
        S_RD_WAIT,
        S_SWAP_RB,
        S_SWAP_WA,
        S_SWAP_WB,
        S_DONE
    } t_state;

    t_state            r_state;
    logic [MODE_W-1:0] r_mode;
    logic [ID_W-1:0]   r_item_id;
    logic [SLOT_W-1:0] r_slot_a;
    logic [SLOT_W-1:0] r_slot_b;
    logic [SLOTS-1:0]  r_used;
    logic [CNT_W-1:0]  r_count;
    logic [IW-1:0]     r_idx;
    logic [IW-1:0]     r_cmp_idx;
    logic              r_issue;
    logic              r_cmp_vld;
    logic [ID_W-1:0]   r_tmp;
    logic              r_ok;
    logic [SLOT_W-1:0] r_slot_res;
    logic [ID_W-1:0]   r_item_res;

    logic              r_out_valid;
    logic              r_out_ok;
    logic [SLOT_W-1:0] r_out_slot;
    logic [ID_W-1:0]   r_out_item;
    logic [CNT_W-1:0]  r_out_count;
    logic              r_out_full;
    logic              r_out_empty;

    t_ram_cmd          n_ram_cmd;
    logic [IW-1:0]     n_ram_addr;
    logic [ID_W-1:0]   n_ram_wdata;
    logic [ID_W-1:0]   ram_rdata;

    logic [IW-1:0]     idx_a;
    logic [IW-1:0]     idx_b;
    logic              a_ok;
    logic              b_ok;
    logic              add_slot_go;
    logic              rd_slot_go;
    logic              swap_go;
    logic              id_hit;

    assign idx_a       = r_slot_a[IW-1:0];
    assign idx_b       = r_slot_b[IW-1:0];
    assign a_ok        = CNT_W'(r_slot_a) < FULL_CNT;
    assign b_ok        = CNT_W'(r_slot_b) < FULL_CNT;
    assign add_slot_go = a_ok && !r_used[idx_a];
    assign rd_slot_go  = a_ok && r_used[idx_a];
    assign swap_go     = a_ok && b_ok;
    assign id_hit      = r_cmp_vld && r_used[r_cmp_idx] && (ram_rdata == r_item_id);

    // id store port control
    always_comb begin
        n_ram_cmd   = '0;
        n_ram_addr  = idx_a;
        n_ram_wdata = r_item_id;
        unique case (r_state)
            S_DISPATCH: begin
                unique case (t_mode'(r_mode))
                    MODE_ADD_SLOT: n_ram_cmd.we = add_slot_go;
                    MODE_REM_SLOT,
                    MODE_READ:     n_ram_cmd.re = rd_slot_go;
                    MODE_SWAP:     n_ram_cmd.re = swap_go;
                    default:       n_ram_cmd    = '0;
                endcase
            end
            S_FREE_SCAN: begin
                n_ram_addr   = r_idx;
                n_ram_cmd.we = !r_used[r_idx];
            end
            S_ID_SCAN: begin
                n_ram_addr   = r_idx;
                n_ram_cmd.re = r_issue;
            end
            S_SWAP_RB: begin
                n_ram_addr   = idx_b;
                n_ram_cmd.re = 1'b1;
            end
            S_SWAP_WA: begin
                n_ram_addr   = idx_a;
                n_ram_wdata  = ram_rdata;
                n_ram_cmd.we = 1'b1;
            end
            S_SWAP_WB: begin
                n_ram_addr   = idx_b;
                n_ram_wdata  = r_tmp;
                n_ram_cmd.we = 1'b1;
            end
            default: n_ram_cmd = '0;
        endcase
    end

    stfs_item_ram #(
        .SLOTS (SLOTS)
    ) u_item_ram (
        .i_clk   (i_clk),
        .i_cmd   (n_ram_cmd),
        .i_addr  (n_ram_addr),
        .i_wdata (n_ram_wdata),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= '0;
            r_count     <= '0;
            r_issue     <= 1'b0;
            r_cmp_vld   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_mode     <= i_mode;
                        r_item_id  <= i_item_id;
                        r_slot_a   <= i_slot_a;
                        r_slot_b   <= i_slot_b;
                        r_ok       <= 1'b0;
                        r_slot_res <= '0;
                        r_item_res <= '0;
                        r_state    <= S_DISPATCH;
                    end
                end
                S_DISPATCH: begin
                    unique case (t_mode'(r_mode))
                        MODE_ADD_FIRST: begin
                            r_idx <= '0;
                            if (r_count == FULL_CNT) begin
                                r_state <= S_DONE;
                            end else begin
                                r_state <= S_FREE_SCAN;
                            end
                        end
                        MODE_ADD_SLOT: begin
                            if (add_slot_go) begin
                                r_used[idx_a] <= 1'b1;
                                r_count       <= r_count + CNT_W'(1);
                                r_ok          <= 1'b1;
                            end
                            r_state <= S_DONE;
                        end
                        MODE_REM_ID: begin
                            r_idx     <= '0;
                            r_issue   <= 1'b1;
                            r_cmp_vld <= 1'b0;
                            r_state   <= S_ID_SCAN;
                        end
                        MODE_REM_SLOT: begin
                            if (rd_slot_go) begin
                                r_used[idx_a] <= 1'b0;
                                r_count       <= r_count - CNT_W'(1);
                                r_state       <= S_RD_WAIT;
                            end else begin
                                r_state <= S_DONE;
                            end
                        end
                        MODE_READ: begin
                            if (rd_slot_go) begin
                                r_state <= S_RD_WAIT;
                            end else begin
                                r_state <= S_DONE;
                            end
                        end
                        MODE_SWAP: begin
                            if (swap_go) begin
                                r_used[idx_a] <= r_used[idx_b];
                                r_used[idx_b] <= r_used[idx_a];
                                r_ok          <= 1'b1;
                                r_state       <= S_SWAP_RB;
                            end else begin
                                r_state <= S_DONE;
                            end
                        end
                        MODE_CLEAR: begin
                            r_used  <= '0;
                            r_count <= '0;
                            r_ok    <= 1'b1;
                            r_state <= S_DONE;
                        end
                        default: r_state <= S_DONE;
                    endcase
                end
                S_FREE_SCAN: begin
                    if (!r_used[r_idx]) begin
                        r_used[r_idx] <= 1'b1;
                        r_count       <= r_count + CNT_W'(1);
                        r_ok          <= 1'b1;
                        r_slot_res    <= SLOT_W'(r_idx);
                        r_state       <= S_DONE;
                    end else if (r_idx == LAST) begin
                        r_state <= S_DONE;
                    end else begin
                        r_idx <= r_idx + IW'(1);
                    end
                end
                S_ID_SCAN: begin
                    // read of r_idx overlaps compare of r_cmp_idx
                    if (id_hit) begin
                        r_used[r_cmp_idx] <= 1'b0;
                        r_count           <= r_count - CNT_W'(1);
                        r_ok              <= 1'b1;
                        r_issue           <= 1'b0;
                        r_cmp_vld         <= 1'b0;
                        r_state           <= S_DONE;
                    end else if (r_cmp_vld && (r_cmp_idx == LAST)) begin
                        r_issue   <= 1'b0;
                        r_cmp_vld <= 1'b0;
                        r_state   <= S_DONE;
                    end else begin
                        r_cmp_vld <= r_issue;
                        r_cmp_idx <= r_idx;
                        if (r_idx == LAST) begin
                            r_issue <= 1'b0;
                        end else begin
                            r_idx <= r_idx + IW'(1);
                        end
                    end
                end
                S_RD_WAIT: begin
                    r_item_res <= ram_rdata;
                    r_ok       <= 1'b1;
                    r_state    <= S_DONE;
                end
                S_SWAP_RB: begin
                    r_tmp   <= ram_rdata;
                    r_state <= S_SWAP_WA;
                end
                S_SWAP_WA: begin
                    r_state <= S_SWAP_WB;
                end
                S_SWAP_WB: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || !i_stall) begin
                        r_out_valid <= 1'b1;
                        r_out_ok    <= r_ok;
                        r_out_slot  <= r_slot_res;
                        r_out_item  <= r_item_res;
                        r_out_count <= r_count;
                        r_out_full  <= (r_count == FULL_CNT);
                        r_out_empty <= (r_count == '0);
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_stall          = (r_state != S_IDLE);
    assign o_valid          = r_out_valid;
    assign o_ok             = r_out_ok;
    assign o_slot_out       = r_out_slot;
    assign o_item_out       = r_out_item;
    assign o_occupied_count = r_out_count;
    assign o_table_full     = r_out_full;
    assign o_table_empty    = r_out_empty;

endmodule

// ===== tb/slot_table_first_free_with_id_search_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// slot_table_first_free_with_id_search_tb
// self-checking testbench for the slot table with first-free allocation
//
// a directed part fills every slot, then walks the reject, swap, id search
// and clear cases; random mixes follow with fill-heavy, drain-heavy and
// balanced request streams. a behavioral copy of the table predicts every
// result at request acceptance; results are checked in order, field by
// field. both channels idle and stall at random, with bursts of no idling.
// ----------------------------------------------------------------------------
module slot_table_first_free_with_id_search_tb;

    import stfs_pkg::*;

    localparam int SLOTS          = 16;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 40;

    localparam logic [MODE_W-1:0] MODE_RESERVED = 3'd7;

    typedef struct packed {
        logic              ok;
        logic [SLOT_W-1:0] slot_out;
        logic [ID_W-1:0]   item_out;
        logic [CNT_W-1:0]  occupied;
        logic              full;
        logic              empty;
    } t_slot_result;

    logic               i_clk     = 1'b0;
    logic               i_rst_n   = 1'b0;
    logic               i_valid   = 1'b0;
    logic               o_stall;
    logic [MODE_W-1:0]  i_mode    = '0;
    logic [ID_W-1:0]    i_item_id = '0;
    logic [SLOT_W-1:0]  i_slot_a  = '0;
    logic [SLOT_W-1:0]  i_slot_b  = '0;
    logic               o_valid;
    logic               i_stall   = 1'b0;
    logic               o_ok;
    logic [SLOT_W-1:0]  o_slot_out;
    logic [ID_W-1:0]    o_item_out;
    logic [CNT_W-1:0]   o_occupied_count;
    logic               o_table_full;
    logic               o_table_empty;

    logic               table_used [SLOTS];
    logic [ID_W-1:0]    table_id   [SLOTS];
    logic [ID_W-1:0]    id_pool    [8];
    t_slot_result       pending_results[$];

    int errors       = 0;
    int tx_burst     = 0;
    int rx_burst     = 0;
    int rx_hold      = 0;
    int idle_cycles  = 0;

    slot_table_first_free_with_id_search #(
        .SLOTS(SLOTS)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_mode           (i_mode),
        .i_item_id        (i_item_id),
        .i_slot_a         (i_slot_a),
        .i_slot_b         (i_slot_b),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_ok             (o_ok),
        .o_slot_out       (o_slot_out),
        .o_item_out       (o_item_out),
        .o_occupied_count (o_occupied_count),
        .o_table_full     (o_table_full),
        .o_table_empty    (o_table_empty)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic int draw_wait(inout int burst);
        if (burst > 0) begin
            burst--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            burst = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, 11);
    endfunction

    // table behavior, applied in acceptance order
    function automatic t_slot_result apply_request(input logic [MODE_W-1:0] mode,
                                                   input logic [ID_W-1:0] id,
                                                   input logic [SLOT_W-1:0] a,
                                                   input logic [SLOT_W-1:0] b);
        t_slot_result    r;
        int              i;
        int              hit;
        int              n;
        logic            tmp_used;
        logic [ID_W-1:0] tmp_id;
        r   = '0;
        hit = -1;
        case (mode)
            MODE_ADD_FIRST: begin
                for (i = 0; i < SLOTS; i++)
                    if (hit < 0 && !table_used[i]) hit = i;
                if (hit >= 0) begin
                    table_used[hit] = 1'b1;
                    table_id[hit]   = id;
                    r.ok            = 1'b1;
                    r.slot_out      = SLOT_W'(hit);
                end
            end
            MODE_ADD_SLOT: begin
                if (a < SLOTS && !table_used[a]) begin
                    table_used[a] = 1'b1;
                    table_id[a]   = id;
                    r.ok          = 1'b1;
                end
            end
            MODE_REM_ID: begin
                for (i = 0; i < SLOTS; i++)
                    if (hit < 0 && table_used[i] && table_id[i] == id) hit = i;
                if (hit >= 0) begin
                    table_used[hit] = 1'b0;
                    r.ok            = 1'b1;
                end
            end
            MODE_REM_SLOT: begin
                if (a < SLOTS && table_used[a]) begin
                    r.item_out    = table_id[a];
                    table_used[a] = 1'b0;
                    r.ok          = 1'b1;
                end
            end
            MODE_SWAP: begin
                if (a < SLOTS && b < SLOTS) begin
                    tmp_used      = table_used[a];
                    tmp_id        = table_id[a];
                    table_used[a] = table_used[b];
                    table_id[a]   = table_id[b];
                    table_used[b] = tmp_used;
                    table_id[b]   = tmp_id;
                    r.ok          = 1'b1;
                end
            end
            MODE_READ: begin
                if (a < SLOTS && table_used[a]) begin
                    r.item_out = table_id[a];
                    r.ok       = 1'b1;
                end
            end
            MODE_CLEAR: begin
                for (i = 0; i < SLOTS; i++) table_used[i] = 1'b0;
                r.ok = 1'b1;
            end
            default: ;
        endcase
        n = 0;
        for (i = 0; i < SLOTS; i++)
            if (table_used[i]) n++;
        r.occupied = CNT_W'(n);
        r.full     = (n == SLOTS);
        r.empty    = (n == 0);
        return r;
    endfunction

    task automatic send_request(input logic [MODE_W-1:0] mode, input logic [ID_W-1:0] id,
                                input logic [SLOT_W-1:0] a, input logic [SLOT_W-1:0] b);
        int gap;
        gap = draw_wait(tx_burst);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_mode    <= mode;
        i_item_id <= id;
        i_slot_a  <= a;
        i_slot_b  <= b;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pending_results.push_back(apply_request(mode, id, a, b));
    endtask

    function automatic logic [ID_W-1:0] pick_id();
        if ($urandom_range(0, 1) == 0) return id_pool[$urandom_range(0, 7)];
        return ID_W'($urandom_range(0, 65535));
    endfunction

    function automatic logic [SLOT_W-1:0] pick_slot();
        if ($urandom_range(0, 99) < 88) return SLOT_W'($urandom_range(0, SLOTS - 1));
        return SLOT_W'($urandom_range(SLOTS, 255));
    endfunction

    function automatic logic [ID_W-1:0] pick_stored_id();
        int held[$];
        int i;
        for (i = 0; i < SLOTS; i++)
            if (table_used[i]) held.push_back(i);
        if (held.size() == 0 || $urandom_range(0, 9) < 3) return pick_id();
        return table_id[held[$urandom_range(0, held.size() - 1)]];
    endfunction

    // every slot written once so that no id read ever sees an unwritten entry
    task automatic test_fill_to_full();
        int i;
        for (i = 0; i < SLOTS; i++) begin
            if (i == 0)
                send_request(MODE_ADD_FIRST, 16'h0000, pick_slot(), pick_slot());
            else if (i == 1)
                send_request(MODE_ADD_FIRST, 16'hFFFF, pick_slot(), pick_slot());
            else if (i == 2 || i == 4)
                send_request(MODE_ADD_FIRST, 16'hA5A5, pick_slot(), pick_slot());
            else
                send_request(MODE_ADD_FIRST, pick_id(), pick_slot(), pick_slot());
        end
        send_request(MODE_ADD_FIRST, 16'h1234, 8'd0, 8'd0);
    endtask

    task automatic test_slot_ops();
        send_request(MODE_ADD_SLOT, 16'h1234, 8'd15, 8'd0);
        send_request(MODE_ADD_SLOT, 16'h1234, 8'(SLOTS), 8'd0);
        send_request(MODE_REM_ID, 16'hA5A5, 8'd0, 8'd0);
        send_request(MODE_READ, 16'h0000, 8'd4, 8'd0);
        send_request(MODE_SWAP, 16'h0000, 8'd2, 8'd15);
        send_request(MODE_SWAP, 16'h0000, 8'd7, 8'd7);
        send_request(MODE_SWAP, 16'h0000, 8'd3, 8'd255);
        send_request(MODE_REM_SLOT, 16'h0000, 8'd255, 8'd0);
        send_request(MODE_REM_SLOT, 16'h0000, 8'd15, 8'd0);
        send_request(MODE_REM_SLOT, 16'h0000, 8'd2, 8'd0);
        send_request(MODE_ADD_FIRST, 16'h5A5A, 8'd0, 8'd0);
        send_request(MODE_RESERVED, 16'hFFFF, 8'd1, 8'd2);
    endtask

    task automatic test_clear_and_empty();
        send_request(MODE_CLEAR, 16'h0000, 8'd0, 8'd0);
        send_request(MODE_READ, 16'h0000, 8'd5, 8'd0);
        send_request(MODE_REM_SLOT, 16'h0000, 8'd5, 8'd0);
        send_request(MODE_REM_ID, 16'h0000, 8'd0, 8'd0);
        send_request(MODE_SWAP, 16'h0000, 8'd0, 8'd1);
        send_request(MODE_ADD_SLOT, 16'hFFFF, 8'd255, 8'd0);
        send_request(MODE_ADD_FIRST, 16'h00FF, 8'd0, 8'd0);
    endtask

    task automatic test_random_mix(input int count, input int add_pct);
        int k;
        int r;
        for (k = 0; k < count; k++) begin
            r = $urandom_range(0, 99);
            if (r < add_pct) begin
                if ($urandom_range(0, 1) == 0)
                    send_request(MODE_ADD_FIRST, pick_id(), pick_slot(), pick_slot());
                else
                    send_request(MODE_ADD_SLOT, pick_id(), pick_slot(), pick_slot());
            end else begin
                r = $urandom_range(0, 99);
                if (r < 34)
                    send_request(MODE_REM_ID, pick_stored_id(), pick_slot(), pick_slot());
                else if (r < 60)
                    send_request(MODE_REM_SLOT, pick_id(), pick_slot(), pick_slot());
                else if (r < 76)
                    send_request(MODE_SWAP, pick_id(), pick_slot(), pick_slot());
                else if (r < 96)
                    send_request(MODE_READ, pick_id(), pick_slot(), pick_slot());
                else if (r < 98)
                    send_request(MODE_CLEAR, pick_id(), pick_slot(), pick_slot());
                else
                    send_request(MODE_RESERVED, pick_id(), pick_slot(), pick_slot());
            end
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_slot_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: result with no request pending, expected none, actual ok %0b",
                             $time, o_ok);
            end else begin
                want = pending_results.pop_front();
                check_field("ok", 32'(want.ok), 32'(o_ok));
                check_field("slot_out", 32'(want.slot_out), 32'(o_slot_out));
                check_field("item_out", 32'(want.item_out), 32'(o_item_out));
                check_field("occupied_count", 32'(want.occupied), 32'(o_occupied_count));
                check_field("table_full", 32'(want.full), 32'(o_table_full));
                check_field("table_empty", 32'(want.empty), 32'(o_table_empty));
            end
        end
    end

    always @(posedge i_clk) begin : rx_drive
        int hold;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            rx_hold <= 0;
        end else if (o_valid && !i_stall) begin
            hold = draw_wait(rx_burst);
            rx_hold <= hold;
            i_stall <= (hold != 0);
        end else if (rx_hold > 1) begin
            rx_hold <= rx_hold - 1;
        end else begin
            rx_hold <= 0;
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("** slot_table_first_free_with_id_search: FAILED **");
                $finish;
            end
        end
    end

    initial begin
        int i;
        for (i = 0; i < 8; i++) id_pool[i] = ID_W'($urandom_range(0, 65535));
        for (i = 0; i < SLOTS; i++) begin
            table_used[i] = 1'b0;
            table_id[i]   = '0;
        end
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_fill_to_full();
        test_slot_ops();
        test_clear_and_empty();
        test_random_mix(450, 75);
        test_random_mix(400, 25);
        test_random_mix(250, 50);

        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SLOTS + 8) @(posedge i_clk);

        if (errors == 0)
            $display("** slot_table_first_free_with_id_search: PASSED **");
        else
            $display("** slot_table_first_free_with_id_search: FAILED **");
        $finish;
    end

endmodule
